### src/gbn_pkg.sv
package gbn_pkg;

  localparam int MAX_N       = 32;
  localparam int MAX_TARGETS = 1023;
  localparam int COORD_W     = 5;
  localparam int CELL_AW     = 10;
  localparam int CELLS       = MAX_N * MAX_N;
  localparam int ID_W        = 10;
  localparam int DIST_W      = 10;
  localparam int SIZE_W      = 6;
  localparam int QPTR_W      = CELL_AW + 1;

  // Cell store entry: wall flag above the target number.
  localparam int CELL_W = ID_W + 1;
  // Search store entry: seen flag above the distance.
  localparam int VIS_W  = DIST_W + 1;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_NEAR  = 2'd1,
    OP_DIST  = 2'd2,
    OP_MARK  = 2'd3
  } op_t;

  localparam logic [1:0] KIND_WALL   = 2'd1;
  localparam logic [1:0] KIND_TARGET = 2'd2;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(MAX_N);
  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(32);

  localparam logic [0:0] REG_GRID_SIZE = 1'b0;

  typedef struct packed {
    logic              found;
    logic [COORD_W-1:0] hit_row;
    logic [COORD_W-1:0] hit_col;
    logic [DIST_W-1:0]  distance;
    logic [ID_W-1:0]    hit_target;
  } res_t;

endpackage

### src/grid_bfs_nearest_target.sv
// Breadth-first search over a square grid of up to 32 x 32 cells kept in on-chip
// memories. Cell writes and served marks are done in the idle state. A nearest or
// distance query whose start lies in the grid (one outside it gives a miss) first
// clears the search map, then expands every reachable cell through one shared
// read-modify-write sequencer: a cell comes off the queue through S_POP, S_CUR1,
// S_CUR2 and S_CUR3, and each in-grid neighbour passes S_NB and S_NB2 while an
// off-grid one passes S_NB only, a sequence set by the single read port of each
// memory. After reset the block clears the cell and served maps before it takes
// its first beat; the grid_size register can be written at any time over the APB
// port.
module grid_bfs_nearest_target (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [4:0]  in_row,
  input  logic [4:0]  in_col,
  input  logic [4:0]  in_end_row,
  input  logic [4:0]  in_end_col,
  input  logic [1:0]  in_cell_kind,
  input  logic [9:0]  in_target_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [4:0]  out_hit_row,
  output logic [4:0]  out_hit_col,
  output logic [9:0]  out_distance,
  output logic [9:0]  out_hit_target
);
  import gbn_pkg::*;

  logic [SIZE_W-1:0] grid_r;
  logic [SIZE_W-1:0] n_eff;
  logic              cfg_wr;
  logic              res_valid, res_take;
  res_t              res;
  res_t              out_r;
  logic              out_valid_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_GRID_SIZE) ? {26'd0, grid_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= SIZE_RST;
    end else if (cfg_wr && (cfg_paddr[2] == REG_GRID_SIZE)) begin
      grid_r <= cfg_pwdata[SIZE_W-1:0];
    end
  end

  assign n_eff = (grid_r < SIZE_MIN) ? SIZE_MIN : ((grid_r > SIZE_MAX) ? SIZE_MAX : grid_r);

  gbn_engine u_engine (
    .clk(clk), .rst_n(rst_n), .n(n_eff),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_row(in_row), .in_col(in_col), .in_end_row(in_end_row), .in_end_col(in_end_col),
    .in_cell_kind(in_cell_kind), .in_target_id(in_target_id),
    .res_valid(res_valid), .res(res), .res_take(res_take)
  );

  // The output register frees the engine as soon as a result beat is parked.
  assign res_take = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_r.found;
  assign out_hit_row    = out_r.hit_row;
  assign out_hit_col    = out_r.hit_col;
  assign out_distance   = out_r.distance;
  assign out_hit_target = out_r.hit_target;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_hit_row == '0 && out_hit_col == '0 &&
                                   out_distance == '0 && out_hit_target == '0))
    else $error("result without a hit carries non-zero fields");

  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    (n_eff >= SIZE_MIN) && (n_eff <= SIZE_MAX))
    else $error("effective grid size out of range");

  a_idle_no_res: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res_valid)
    else $error("engine offers a result while taking new beats");

endmodule

### src/gbn_ram.sv
module gbn_ram #(
  parameter int W = 8,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/gbn_engine.sv
module gbn_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [gbn_pkg::SIZE_W-1:0]   n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_opcode,
  input  logic [gbn_pkg::COORD_W-1:0]  in_row,
  input  logic [gbn_pkg::COORD_W-1:0]  in_col,
  input  logic [gbn_pkg::COORD_W-1:0]  in_end_row,
  input  logic [gbn_pkg::COORD_W-1:0]  in_end_col,
  input  logic [1:0]                   in_cell_kind,
  input  logic [gbn_pkg::ID_W-1:0]     in_target_id,
  output logic                         res_valid,
  output gbn_pkg::res_t                res,
  input  logic                         res_take
);
  import gbn_pkg::*;

  typedef enum logic [12:0] {
    S_CLR  = 13'b0000000000001,
    S_IDLE = 13'b0000000000010,
    S_SWP  = 13'b0000000000100,
    S_SEED = 13'b0000000001000,
    S_POP  = 13'b0000000010000,
    S_CUR1 = 13'b0000000100000,
    S_CUR2 = 13'b0000001000000,
    S_CUR3 = 13'b0000010000000,
    S_NB   = 13'b0000100000000,
    S_NB2  = 13'b0001000000000,
    S_FIN  = 13'b0010000000000,
    S_FIN2 = 13'b0100000000000,
    S_OUT  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic               near_r, near_nxt;
  logic [CELL_AW-1:0] start_r, start_nxt;
  logic [COORD_W-1:0] erow_r, erow_nxt, ecol_r, ecol_nxt;
  logic [CELL_AW-1:0] cnt_r, cnt_nxt;
  logic [QPTR_W-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [CELL_AW-1:0] cur_r, cur_nxt;
  logic [DIST_W-1:0]  curd_r, curd_nxt;
  logic [ID_W-1:0]    tgt_r, tgt_nxt;
  logic [1:0]         dir_r, dir_nxt;
  logic [CELL_AW-1:0] ni_r, ni_nxt;
  logic               have_r, have_nxt;
  logic [DIST_W-1:0]  bd_r, bd_nxt;
  logic [CELL_AW-1:0] bi_r, bi_nxt;
  logic [ID_W-1:0]    bt_r, bt_nxt;
  res_t               res_r, res_nxt;

  logic               cell_we, srv_we, vis_we, que_we;
  logic [CELL_AW-1:0] cell_wa, cell_ra, vis_wa, vis_ra, que_wa, que_ra;
  logic [ID_W-1:0]    srv_wa, srv_ra;
  logic [CELL_W-1:0]  cell_wd, cell_rd;
  logic               srv_wd, srv_rd;
  logic [VIS_W-1:0]   vis_wd, vis_rd;
  logic [CELL_AW-1:0] que_wd, que_rd;

  gbn_ram #(.W(CELL_W), .D(CELLS)) u_cell (
    .clk(clk), .we(cell_we), .waddr(cell_wa), .wdata(cell_wd), .raddr(cell_ra), .rdata(cell_rd)
  );
  gbn_ram #(.W(1), .D(MAX_TARGETS + 1)) u_srv (
    .clk(clk), .we(srv_we), .waddr(srv_wa), .wdata(srv_wd), .raddr(srv_ra), .rdata(srv_rd)
  );
  gbn_ram #(.W(VIS_W), .D(CELLS)) u_vis (
    .clk(clk), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd), .raddr(vis_ra), .rdata(vis_rd)
  );
  gbn_ram #(.W(CELL_AW), .D(CELLS)) u_que (
    .clk(clk), .we(que_we), .waddr(que_wa), .wdata(que_wd), .raddr(que_ra), .rdata(que_rd)
  );

  // Neighbour of the cell being expanded, in the direction dir_r.
  logic [COORD_W-1:0] cr, cc, nr, nc;
  logic [SIZE_W-1:0]  cr_inc, cc_inc;
  logic               nb_ok;
  logic               cand_better;

  always_comb begin
    cr     = cur_r[CELL_AW-1:COORD_W];
    cc     = cur_r[COORD_W-1:0];
    cr_inc = {1'b0, cr} + SIZE_W'(1);
    cc_inc = {1'b0, cc} + SIZE_W'(1);
    nr     = cr;
    nc     = cc;
    nb_ok  = 1'b0;
    case (dir_r)
      DIR_UP: begin
        nb_ok = (cr != '0);
        nr    = cr - COORD_W'(1);
      end
      DIR_LEFT: begin
        nb_ok = (cc != '0);
        nc    = cc - COORD_W'(1);
      end
      DIR_DOWN: begin
        nb_ok = (cr_inc < n);
        nr    = cr_inc[COORD_W-1:0];
      end
      default: begin
        nb_ok = (cc_inc < n);
        nc    = cc_inc[COORD_W-1:0];
      end
    endcase
  end

  // Ties at equal distance go to the lower cell index, which is row first, then column.
  assign cand_better = !have_r || (curd_r < bd_r) || ((curd_r == bd_r) && (cur_r < bi_r));

  always_comb begin
    state_nxt = state_r;
    near_nxt  = near_r;
    start_nxt = start_r;
    erow_nxt  = erow_r;
    ecol_nxt  = ecol_r;
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cur_nxt   = cur_r;
    curd_nxt  = curd_r;
    tgt_nxt   = tgt_r;
    dir_nxt   = dir_r;
    ni_nxt    = ni_r;
    have_nxt  = have_r;
    bd_nxt    = bd_r;
    bi_nxt    = bi_r;
    bt_nxt    = bt_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    res_valid = 1'b0;
    cell_we = 1'b0; cell_wa = '0; cell_wd = '0; cell_ra = '0;
    srv_we  = 1'b0; srv_wa  = '0; srv_wd  = 1'b0; srv_ra = '0;
    vis_we  = 1'b0; vis_wa  = '0; vis_wd  = '0; vis_ra = '0;
    que_we  = 1'b0; que_wa  = '0; que_wd  = '0; que_ra = '0;

    unique case (state_r)
      S_CLR: begin
        cell_we = 1'b1;
        cell_wa = cnt_r;
        srv_we  = 1'b1;
        srv_wa  = cnt_r;
        cnt_nxt = cnt_r + CELL_AW'(1);
        if (cnt_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (op_t'(in_opcode))
            OP_WRITE: begin
              cell_we = 1'b1;
              cell_wa = {in_row, in_col};
              cell_wd = {in_cell_kind == KIND_WALL,
                         (in_cell_kind == KIND_TARGET) ? in_target_id : ID_W'(0)};
            end
            OP_MARK: begin
              srv_we = (in_target_id != '0);
              srv_wa = in_target_id;
              srv_wd = 1'b1;
            end
            default: begin
              near_nxt  = (op_t'(in_opcode) == OP_NEAR);
              start_nxt = {in_row, in_col};
              erow_nxt  = in_end_row;
              ecol_nxt  = in_end_col;
              have_nxt  = 1'b0;
              cnt_nxt   = '0;
              if (({1'b0, in_row} >= n) || ({1'b0, in_col} >= n)) begin
                res_nxt   = '0;
                state_nxt = S_OUT;
              end else begin
                state_nxt = S_SWP;
              end
            end
          endcase
        end
      end
      S_SWP: begin
        vis_we  = 1'b1;
        vis_wa  = cnt_r;
        cnt_nxt = cnt_r + CELL_AW'(1);
        if (cnt_r == '1) begin
          state_nxt = S_SEED;
        end
      end
      S_SEED: begin
        vis_we    = 1'b1;
        vis_wa    = start_r;
        vis_wd    = {1'b1, DIST_W'(0)};
        que_we    = 1'b1;
        que_wa    = '0;
        que_wd    = start_r;
        head_nxt  = '0;
        tail_nxt  = QPTR_W'(1);
        state_nxt = S_POP;
      end
      S_POP: begin
        if (head_r == tail_r) begin
          state_nxt = S_FIN;
        end else begin
          que_ra    = head_r[CELL_AW-1:0];
          head_nxt  = head_r + QPTR_W'(1);
          state_nxt = S_CUR1;
        end
      end
      S_CUR1: begin
        cur_nxt   = que_rd;
        vis_ra    = que_rd;
        cell_ra   = que_rd;
        state_nxt = S_CUR2;
      end
      S_CUR2: begin
        curd_nxt  = vis_rd[DIST_W-1:0];
        tgt_nxt   = cell_rd[ID_W-1:0];
        srv_ra    = cell_rd[ID_W-1:0];
        state_nxt = S_CUR3;
      end
      S_CUR3: begin
        if (near_r && (tgt_r != '0) && !srv_rd && cand_better) begin
          have_nxt = 1'b1;
          bd_nxt   = curd_r;
          bi_nxt   = cur_r;
          bt_nxt   = tgt_r;
        end
        dir_nxt   = DIR_UP;
        state_nxt = S_NB;
      end
      S_NB: begin
        if (nb_ok) begin
          cell_ra   = {nr, nc};
          vis_ra    = {nr, nc};
          ni_nxt    = {nr, nc};
          state_nxt = S_NB2;
        end else if (dir_r == DIR_RIGHT) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt = dir_r + 2'd1;
        end
      end
      S_NB2: begin
        // Wall neighbours are never entered and each cell joins the queue once.
        if (!cell_rd[CELL_W-1] && !vis_rd[VIS_W-1]) begin
          vis_we   = 1'b1;
          vis_wa   = ni_r;
          vis_wd   = {1'b1, curd_r + DIST_W'(1)};
          que_we   = 1'b1;
          que_wa   = tail_r[CELL_AW-1:0];
          que_wd   = ni_r;
          tail_nxt = tail_r + QPTR_W'(1);
        end
        if (dir_r == DIR_RIGHT) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt   = dir_r + 2'd1;
          state_nxt = S_NB;
        end
      end
      S_FIN: begin
        res_nxt = '0;
        if (near_r) begin
          if (have_r) begin
            res_nxt.found      = 1'b1;
            res_nxt.hit_row    = bi_r[CELL_AW-1:COORD_W];
            res_nxt.hit_col    = bi_r[COORD_W-1:0];
            res_nxt.distance   = bd_r;
            res_nxt.hit_target = bt_r;
          end
          state_nxt = S_OUT;
        end else if (({1'b0, erow_r} >= n) || ({1'b0, ecol_r} >= n)) begin
          state_nxt = S_OUT;
        end else begin
          vis_ra    = {erow_r, ecol_r};
          state_nxt = S_FIN2;
        end
      end
      S_FIN2: begin
        res_nxt = '0;
        if (vis_rd[VIS_W-1]) begin
          res_nxt.found    = 1'b1;
          res_nxt.hit_row  = erow_r;
          res_nxt.hit_col  = ecol_r;
          res_nxt.distance = vis_rd[DIST_W-1:0];
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      have_r  <= 1'b0;
      head_r  <= '0;
      tail_r  <= '0;
      dir_r   <= DIR_UP;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      have_r  <= have_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      dir_r   <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    near_r  <= near_nxt;
    start_r <= start_nxt;
    erow_r  <= erow_nxt;
    ecol_r  <= ecol_nxt;
    cur_r   <= cur_nxt;
    curd_r  <= curd_nxt;
    tgt_r   <= tgt_nxt;
    ni_r    <= ni_nxt;
    bd_r    <= bd_nxt;
    bi_r    <= bi_nxt;
    bt_r    <= bt_nxt;
    res_r   <= res_nxt;
  end

endmodule
